[design/dwf_pkg.sv]
`default_nettype none
package dwf_pkg;

    localparam int ADDR_W   = 24;
    localparam int LEN_IN_W = 24;
    localparam int START_W  = 25;
    localparam int USE_W    = 18;
    localparam int KB_W     = 8;
    localparam int AL_W     = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PAGE_W   = KB_W + 10;
    localparam int LEN_W    = PAGE_W + 1;
    localparam int BND_W    = START_W + 1;

    // remainder unit widths: dividend and divisor widths cover every use
    localparam int NUM_W     = BND_W;
    localparam int DEN_W     = PAGE_W;
    localparam int REM_STEPS = NUM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_KB     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY = 2'd2;

    localparam logic [KB_W-1:0] PAGE_KB_RST = 8'd64;
    localparam logic [AL_W-1:0] ALIGN_RST   = 16'd1;
    localparam logic [AL_W-1:0] GRAN_RST    = 16'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [START_W-1:0] start;
        logic [START_W-1:0] chosen;
        logic [BND_W-1:0]   bnd;
        logic [LEN_W-1:0]   len;
        logic [PAGE_W-1:0]  flen;
        logic [LEN_W-1:0]   dsub;
    } t_item;

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [DEN_W-1:0] rem_step(
        input logic [DEN_W-1:0] rem,
        input logic             nbit,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, den}) begin
            t = t - {1'b0, den};
        end
        return t[DEN_W-1:0];
    endfunction

endpackage
`default_nettype wire

[design/dwf_rem.sv]
`default_nettype none
module dwf_rem
    import dwf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire t_item            i_item,
    output logic                  o_valid,
    output logic [DEN_W-1:0]      o_rem,
    output t_item                 o_item
);

    logic             r_valid [REM_STEPS];
    logic [DEN_W-1:0] r_rem   [REM_STEPS];
    logic [NUM_W-1:0] r_num   [REM_STEPS];
    t_item            r_item  [REM_STEPS];

    for (genvar k = 0; k < REM_STEPS; k++) begin : g_step
        logic             w_valid;
        logic [DEN_W-1:0] w_rem;
        logic [NUM_W-1:0] w_num;
        t_item            w_item;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_rem   = '0;
            assign w_num   = i_num;
            assign w_item  = i_item;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_num   = r_num[k-1];
            assign w_item  = r_item[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= rem_step(w_rem, w_num[NUM_W-1], i_den);
                r_num[k]  <= {w_num[NUM_W-2:0], 1'b0};
                r_item[k] <= w_item;
            end
        end
    end

    assign o_valid = r_valid[REM_STEPS-1];
    assign o_rem   = r_rem[REM_STEPS-1];
    assign o_item  = r_item[REM_STEPS-1];

endmodule
`default_nettype wire

[design/dma_window_fit_core.sv]
// throughput: one item per cycle while the output is not stalled; four pipelined
// remainder units of 26 one-bit steps each set the depth
// reset: synchronous active-low i_rst_n empties the pipeline and loads
// page_kb 64, alignment 1, granularity 1
`default_nettype none
module dma_window_fit_core
    import dwf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [ADDR_W-1:0]    i_block_address,
    input  wire logic [LEN_IN_W-1:0]  i_block_length,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [START_W-1:0]        o_buffer_start,
    output logic [USE_W-1:0]          o_usable_length
);

    logic [KB_W-1:0] r_page_kb;
    logic [AL_W-1:0] r_align;
    logic [AL_W-1:0] r_gran;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_kb <= PAGE_KB_RST;
            r_align   <= ALIGN_RST;
            r_gran    <= GRAN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PAGE_KB:     r_page_kb <= i_cfg_data[KB_W-1:0];
                CFG_ALIGNMENT:   r_align   <= i_cfg_data;
                CFG_GRANULARITY: r_gran    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [KB_W-1:0]   kb;
    logic [AL_W-1:0]   al;
    logic [AL_W-1:0]   gr;
    logic [PAGE_W-1:0] page;
    logic [LEN_W-1:0]  page2;
    logic              adv;

    assign kb    = (r_page_kb == '0) ? KB_W'(1) : r_page_kb;
    assign al    = (r_align == '0) ? AL_W'(1) : r_align;
    assign gr    = (r_gran == '0) ? AL_W'(1) : r_gran;
    assign page  = {kb, 10'b0};
    assign page2 = {page, 1'b0};

    // whole pipeline moves together whenever the output slot frees up
    logic r_out_valid;
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    // entry: clamp length to two pages
    t_item in_item;
    always_comb begin
        in_item      = '0;
        in_item.addr = i_block_address;
        in_item.len  = (i_block_length > LEN_IN_W'(page2)) ? page2
                                                          : LEN_W'(i_block_length);
    end

    // remainder a: addr % alignment
    logic             a_valid;
    logic [DEN_W-1:0] a_rem;
    t_item            a_item;
    dwf_rem u_rem_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(i_valid && !o_stall), .i_num(NUM_W'(i_block_address)),
        .i_den(DEN_W'(al)), .i_item(in_item),
        .o_valid(a_valid), .o_rem(a_rem), .o_item(a_item)
    );

    // g1: aligned start, trimmed length
    logic        r_g1_valid;
    t_item       r_g1, n_g1;
    logic [AL_W-1:0] pad1;
    always_comb begin
        pad1        = (a_rem == '0) ? '0 : al - a_rem[AL_W-1:0];
        n_g1        = a_item;
        n_g1.start  = START_W'(a_item.addr) + START_W'(pad1);
        n_g1.len    = (a_item.len > LEN_W'(pad1)) ? a_item.len - LEN_W'(pad1) : '0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_valid <= 1'b0;
        end else if (adv) begin
            r_g1_valid <= a_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g1 <= n_g1;
        end
    end

    // remainder b: start % page
    logic             b_valid;
    logic [DEN_W-1:0] b_rem;
    t_item            b_item;
    dwf_rem u_rem_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(r_g1_valid), .i_num(NUM_W'(r_g1.start)),
        .i_den(page), .i_item(r_g1),
        .o_valid(b_valid), .o_rem(b_rem), .o_item(b_item)
    );

    // g2: next page boundary and room before it
    logic  r_g2_valid;
    t_item r_g2, n_g2;
    always_comb begin
        n_g2      = b_item;
        n_g2.bnd  = BND_W'(b_item.start) - BND_W'(b_rem) + BND_W'(page);
        n_g2.flen = page - b_rem;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2_valid <= 1'b0;
        end else if (adv) begin
            r_g2_valid <= b_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g2 <= n_g2;
        end
    end

    // remainder c: boundary % alignment
    logic             c_valid;
    logic [DEN_W-1:0] c_rem;
    t_item            c_item;
    dwf_rem u_rem_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(r_g2_valid), .i_num(r_g2.bnd),
        .i_den(DEN_W'(al)), .i_item(r_g2),
        .o_valid(c_valid), .o_rem(c_rem), .o_item(c_item)
    );

    // g3: aligned start after the boundary
    logic            r_g3_valid;
    t_item           r_g3, n_g3;
    logic [AL_W-1:0] pad2;
    logic [BND_W-1:0] second;
    always_comb begin
        pad2        = (c_rem == '0) ? '0 : al - c_rem[AL_W-1:0];
        second      = c_item.bnd + BND_W'(pad2);
        n_g3        = c_item;
        n_g3.chosen = second[START_W-1:0];
        n_g3.dsub   = LEN_W'(c_item.flen) + LEN_W'(pad2);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g3_valid <= 1'b0;
        end else if (adv) begin
            r_g3_valid <= c_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g3 <= n_g3;
        end
    end

    // g4: pick the side of the boundary, clamp to one page
    logic            r_g4_valid;
    t_item           r_g4, n_g4;
    logic [LEN_W-1:0] l4;
    always_comb begin
        n_g4 = r_g3;
        if (LEN_W'(r_g3.flen) >= (r_g3.len >> 1)) begin
            n_g4.chosen = r_g3.start;
            l4 = (r_g3.len > LEN_W'(r_g3.flen)) ? LEN_W'(r_g3.flen) : r_g3.len;
        end else begin
            l4 = (r_g3.len > r_g3.dsub) ? r_g3.len - r_g3.dsub : '0;
        end
        n_g4.len = (l4 > LEN_W'(page)) ? LEN_W'(page) : l4;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g4_valid <= 1'b0;
        end else if (adv) begin
            r_g4_valid <= r_g3_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g4 <= n_g4;
        end
    end

    // remainder d: length % granularity
    logic             d_valid;
    logic [DEN_W-1:0] d_rem;
    t_item            d_item;
    dwf_rem u_rem_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(r_g4_valid), .i_num(NUM_W'(r_g4.len)),
        .i_den(DEN_W'(gr)), .i_item(r_g4),
        .o_valid(d_valid), .o_rem(d_rem), .o_item(d_item)
    );

    // output register
    logic [START_W-1:0] r_out_start;
    logic [USE_W-1:0]   r_out_len;
    logic [LEN_W-1:0]   fin_len;
    assign fin_len = d_item.len - LEN_W'(d_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_start <= d_item.chosen;
            r_out_len   <= fin_len[USE_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_buffer_start  = r_out_start;
    assign o_usable_length = r_out_len;

endmodule
`default_nettype wire

[design/dwf_checker.sv]
`default_nettype none
module dwf_checker
    import dwf_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [START_W-1:0] o_buffer_start,
    input wire logic [USE_W-1:0]   o_usable_length
);

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_buffer_start)
                               && $stable(o_usable_length))
        else $error("held result changed");

    // input side only backs up when the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without blocked output");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

    // never more than one page of the largest size
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_usable_length <= USE_W'(261120))
        else $error("usable length above page limit");

endmodule

bind dma_window_fit_core dwf_checker u_dwf_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_buffer_start(o_buffer_start),
    .o_usable_length(o_usable_length)
);
`default_nettype wire

[tb/sv/dwf_checker.sv]
`timescale 1ns / 100ps
module dwf_scoreboard
    import dwf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [ADDR_W-1:0]    i_block_address,
    input  logic [LEN_IN_W-1:0]  i_block_length,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [START_W-1:0]   i_buffer_start,
    input  logic [USE_W-1:0]     i_usable_length,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct {
        logic [START_W-1:0] start;
        logic [USE_W-1:0]   length;
    } window_t;

    logic [KB_W-1:0] page_kb_q;
    logic [AL_W-1:0] align_q;
    logic [AL_W-1:0] gran_q;
    window_t         window_q[$];

    function automatic longint unsigned round_up(longint unsigned v, longint unsigned al);
        return v + (al - (v % al)) % al;
    endfunction

    function automatic window_t fit_window(logic [ADDR_W-1:0] a_in, logic [LEN_IN_W-1:0] l_in);
        longint unsigned page, al, gr, addr, len, start, bnd, second, first_len, chosen;
        window_t w;
        page = ((page_kb_q == 0) ? 1 : page_kb_q) << 10;
        al   = (align_q == 0) ? 1 : align_q;
        gr   = (gran_q == 0) ? 1 : gran_q;
        addr = a_in;
        len  = l_in;
        if (len > (page << 1)) len = page << 1;
        start = round_up(addr, al);
        len = (len > start - addr) ? len - (start - addr) : 0;
        bnd = ((start + page) / page) * page;
        second = round_up(bnd, al);
        first_len = bnd - start;
        if (first_len >= (len >> 1)) begin
            chosen = start;
            if (len > first_len) len = first_len;
        end else begin
            chosen = second;
            len = (len > second - start) ? len - (second - start) : 0;
        end
        if (len > page) len = page;
        w.start  = chosen[START_W-1:0];
        w.length = USE_W'(len - (len % gr));
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        window_t w;
        if (!i_rst_n) begin
            page_kb_q <= PAGE_KB_RST;
            align_q   <= ALIGN_RST;
            gran_q    <= GRAN_RST;
            window_q.delete();
            o_errors  <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PAGE_KB:     page_kb_q <= i_cfg_data[KB_W-1:0];
                    CFG_ALIGNMENT:   align_q   <= i_cfg_data;
                    CFG_GRANULARITY: gran_q    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                window_q.push_back(fit_window(i_block_address, i_block_length));
            if (i_out_valid && !i_out_stall) begin
                if (window_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result start=%0h len=%0h",
                                 i_buffer_start, i_usable_length);
                    o_errors <= o_errors + 1;
                end else begin
                    w = window_q.pop_front();
                    if (w.start !== i_buffer_start || w.length !== i_usable_length) begin
                        if (o_errors < 10)
                            $display("mismatch start exp=%0h got=%0h len exp=%0h got=%0h",
                                     w.start, i_buffer_start, w.length, i_usable_length);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    // input side pushes before output pops in the same edge, so count is exact
    assign o_pending = window_q.size();

endmodule

[tb/sv/tb_dma_window_fit_core.sv]
`timescale 1ns / 100ps
module tb_dma_window_fit_core;
    import dwf_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_PAGE_KB;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [ADDR_W-1:0]    i_block_address = '0;
    logic [LEN_IN_W-1:0]  i_block_length = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [START_W-1:0]   o_buffer_start;
    logic [USE_W-1:0]     o_usable_length;
    int                   error_count;
    int                   pending_count;
    int                   stall_pct = 0;
    int                   hold_cycles = 0;

    localparam int LATENCY = 109;

    dma_window_fit_core DUT (.*);

    dwf_scoreboard u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_block_address, .i_block_length,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_buffer_start(o_buffer_start), .i_usable_length(o_usable_length),
        .o_errors(error_count), .o_pending(pending_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_dma_window_fit_core: errors");
        $finish;
    end

    // receiver stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // valid stays high after an item until the next item or an explicit stop
    task automatic send_item(input logic [ADDR_W-1:0] a, input logic [LEN_IN_W-1:0] l,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_block_address <= a;
        i_block_length <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic random_item(input int idle_pct);
        logic [ADDR_W-1:0]   a;
        logic [LEN_IN_W-1:0] l;
        a = ADDR_W'($urandom);
        case ($urandom_range(3))
            0: l = LEN_IN_W'($urandom);
            1: l = LEN_IN_W'($urandom_range(300000));
            2: l = LEN_IN_W'($urandom_range(2000));
            default: l = LEN_IN_W'({$urandom_range(3), 16'hffff} + $urandom_range(2) - 1);
        endcase
        if ($urandom_range(7) == 0)
            a = ADDR_W'({a[ADDR_W-1:16], 16'hffff} - $urandom_range(50));
        send_item(a, l, idle_pct);
    endtask

    initial begin
        logic [KB_W-1:0] kb_set[6];
        logic [AL_W-1:0] al_set[6];
        int idle_pct;
        kb_set = '{8'd64, 8'd128, 8'd0, 8'd1, 8'd255, 8'd4};
        al_set = '{16'd1, 16'd0, 16'd4096, 16'hffff, 16'd3, 16'd512};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at reset settings
        send_item('0, '0, 0);
        send_item('1, '1, 0);
        send_item(24'h00ffff, 24'h000100, 0);
        send_item(24'h00fff0, 24'h020000, 0);
        send_item(24'h010000, 24'h010000, 0);
        send_item(24'h000001, 24'hffffff, 0);
        send_item(24'hfffff0, 24'h000100, 0);
        send_item(24'h123456, 24'h000001, 0);
        drain();
        write_reg(CFG_ALIGNMENT, 16'd0);
        write_reg(CFG_GRANULARITY, 16'd0);
        i_cfg_wr_en <= 1'b0;
        send_item(24'h000123, 24'h001000, 0);
        send_item(24'hffffff, 24'hffffff, 0);
        drain();
        write_reg(CFG_PAGE_KB, 16'd255);
        write_reg(CFG_ALIGNMENT, 16'hffff);
        write_reg(CFG_GRANULARITY, 16'hffff);
        i_cfg_wr_en <= 1'b0;
        send_item(24'h000001, 24'hffffff, 0);
        send_item(24'hfffffe, 24'hffffff, 0);
        send_item(24'h0ffff0, 24'h0fffff, 0);
        drain();
        write_reg(CFG_PAGE_KB, 16'd0);
        write_reg(CFG_ALIGNMENT, 16'd3);
        write_reg(CFG_GRANULARITY, 16'd7);
        i_cfg_wr_en <= 1'b0;
        send_item(24'h0003ff, 24'h000800, 0);
        send_item(24'h000000, 24'h000800, 0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_PAGE_KB, CFG_W'(kb_set[ph % 6]));
            write_reg(CFG_ALIGNMENT, ($urandom_range(3) == 0) ? 16'($urandom)
                                                               : al_set[$urandom_range(5)]);
            write_reg(CFG_GRANULARITY, ($urandom_range(3) == 0) ? 16'($urandom)
                                                                 : al_set[$urandom_range(5)]);
            i_cfg_wr_en <= 1'b0;
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            if (ph == 5) hold_cycles = 400;
            for (int n = 0; n < 150; n++) random_item(idle_pct);
            if (ph == 7) begin
                // pause until every outstanding result has arrived
                i_valid <= 1'b0;
                while (pending_count != 0) @(posedge i_clk);
                for (int n = 0; n < 20; n++) random_item(0);
            end
            drain();
        end
        stall_pct = 0;
        drain();
        if (error_count == 0)
            $display("tb_dma_window_fit_core: clean");
        else
            $display("tb_dma_window_fit_core: errors");
        $finish;
    end

endmodule
